### hdl/imu_pkg.sv
// ----------------------------------------------------------------------------
// IMU tilt/yaw package
// Shared constants, CORDIC beat type and arctangent table.
// ----------------------------------------------------------------------------
package imu_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int XY_W          = 36;
    localparam int Z_W           = 28;

    localparam logic [1:0] REG_AX_OFF = 2'd0;
    localparam logic [1:0] REG_AY_OFF = 2'd1;
    localparam logic [1:0] REG_AZ_OFF = 2'd2;
    localparam logic [1:0] REG_GZ_OFF = 2'd3;

    localparam logic signed [Z_W-1:0] HALF_TURN_Z = 28'sd11796480;
    localparam logic signed [15:0]    ROLL_LIM    = 16'sd23040;
    localparam logic signed [15:0]    PITCH_LIM   = 16'sd11520;

    localparam logic signed [27:0] YAW_HALF = 28'sd23580000;
    localparam logic signed [27:0] YAW_FULL = 28'sd47160000;
    localparam logic [31:0]        YAW_RND  = 32'd65500;

    // divide by 131000: drop 3 low bits, then scale by ceil(2^43 / 16375)
    localparam logic [29:0]        YAW_RECIP       = 30'd537165987;
    localparam int                 YAW_RECIP_SHIFT = 43;

    localparam logic signed [48:0] VEL_MAX = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [48:0] VEL_MIN = -49'sh0_8000_0000_0000;
    localparam logic signed [64:0] POS_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] POS_MIN = -65'sh0_8000_0000_0000_0000;

    typedef struct packed {
        logic                   valid;
        logic                   pitch;
        logic                   zero;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_beat_t;

    function automatic logic signed [Z_W-1:0] atan_lut(input logic [4:0] idx);
        logic signed [Z_W-1:0] a;
        case (idx)
            5'd0:    a = 28'sd2949120;
            5'd1:    a = 28'sd1740967;
            5'd2:    a = 28'sd919879;
            5'd3:    a = 28'sd466945;
            5'd4:    a = 28'sd234379;
            5'd5:    a = 28'sd117304;
            5'd6:    a = 28'sd58666;
            5'd7:    a = 28'sd29335;
            5'd8:    a = 28'sd14668;
            5'd9:    a = 28'sd7334;
            5'd10:   a = 28'sd3667;
            5'd11:   a = 28'sd1833;
            5'd12:   a = 28'sd917;
            5'd13:   a = 28'sd458;
            5'd14:   a = 28'sd229;
            5'd15:   a = 28'sd115;
            5'd16:   a = 28'sd57;
            5'd17:   a = 28'sd29;
            5'd18:   a = 28'sd14;
            5'd19:   a = 28'sd7;
            5'd20:   a = 28'sd4;
            5'd21:   a = 28'sd2;
            5'd22:   a = 28'sd1;
            default: a = 28'sd0;
        endcase
        return a;
    endfunction

endpackage

### hdl/imu_tilt_yaw_and_dead_reckoning_unit.sv
// ----------------------------------------------------------------------------
// IMU tilt, yaw and x dead reckoning
// Roll/pitch by a chain of CORDIC cells, yaw and x motion by integration.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sensor sample per beat (tdata: accel x/y/z, gyro z,
//   elapsed ms). m_axis returns one beat per sample (roll, pitch, yaw,
//   velocity x, position x). cfg writes the four bias registers by index.
//   From accept to result a sample waits for the square root feeding the
//   pitch operand and for the walk of the pitch vector down the CORDIC
//   chain. One sample is in work at a time; s_axis_tready is high in idle
//   once the previous result can move to the output register, so a new
//   sample is not taken before the last one is through. If m_axis_tready
//   is low, the finished result holds in the output register and a following
//   result stalls, with s_axis_tready low, until that beat is taken.
//   Reset clears the biases, the yaw, velocity and position accumulators
//   and all valid flags. cfg_ready is always high; write only while idle.
// ----------------------------------------------------------------------------
module imu_tilt_yaw_and_dead_reckoning_unit
    import imu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // accel_x_raw[15:0], accel_y_raw[31:16], accel_z_raw[47:32],
    // gyro_z_raw[63:48], elapsed_ms[71:64]
    input  logic [71:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // roll_angle[15:0], pitch_angle[30:16], yaw_angle[46:31],
    // velocity_x[94:47], position_x[158:95], zero[159]
    output logic [159:0] m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [16:0]  cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_ACC  = 7'b0000100,
        S_PMUL = 7'b0001000,
        S_POS  = 7'b0010000,
        S_ROOT = 7'b0100000,
        S_WAIT = 7'b1000000
    } state_t;

    state_t state_reg;
    logic   done_reg;

    logic signed [15:0] ax_off_reg;
    logic signed [15:0] ay_off_reg;
    logic signed [16:0] az_off_reg;
    logic signed [15:0] gz_off_reg;

    logic signed [16:0] cx_reg;
    logic signed [16:0] cy_reg;
    logic signed [17:0] cz_reg;
    logic signed [16:0] gz_reg;
    logic [7:0]         ms_reg;

    logic [31:0]        sqy_reg;
    logic [32:0]        sqz_reg;
    logic [33:0]        sq_sum_reg;
    logic signed [25:0] gprod_reg;
    logic signed [25:0] vprod_reg;
    logic               gate_reg;
    logic signed [55:0] d_reg;
    logic [31:0]        yaw_n_reg;
    logic               yaw_neg_reg;

    logic signed [27:0] yaw_reg;
    logic signed [47:0] vel_reg;
    logic signed [63:0] pos_reg;
    logic signed [15:0] roll_reg;
    logic signed [14:0] pitch_reg;

    logic               out_valid_reg;
    logic [159:0]       out_data_reg;

    logic               in_fire;
    logic               load_out;
    logic signed [16:0] cx_in;
    logic signed [16:0] cy_in;
    logic signed [17:0] cz_in;
    logic signed [16:0] gz_in;
    logic [16:0]        cx_mag;
    logic [16:0]        off_mag;
    logic signed [33:0] sqy_full;
    logic signed [35:0] sqz_full;
    logic signed [27:0] yaw_sum;
    logic signed [27:0] yaw_wrap1;
    logic signed [27:0] yaw_wrap2;
    logic signed [48:0] vel_sum;
    logic signed [48:0] vel_sat;
    logic signed [56:0] d_full;
    logic signed [64:0] pos_sum;
    logic [24:0]        yaw_mag;
    logic signed [15:0] yaw_out;

    logic               sqrt_start;
    logic               sqrt_done;
    logic [30:0]        root;
    logic               div_start;
    logic               div_done;
    logic [14:0]        quotient;

    cordic_beat_t       chain [0:CORDIC_STAGES];
    cordic_beat_t       launch;
    cordic_beat_t       tail;
    logic signed [Z_W-1:0] ang_full;
    logic signed [Z_W-1:0] ang_clamped;
    logic signed [Z_W-1:0] lim;

    assign s_axis_tready = (state_reg == S_IDLE) && (!done_reg || load_out);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign cx_in = $signed({s_axis_tdata[15], s_axis_tdata[15:0]})
                   - $signed({ax_off_reg[15], ax_off_reg});
    assign cy_in = $signed({s_axis_tdata[31], s_axis_tdata[31:16]})
                   - $signed({ay_off_reg[15], ay_off_reg});
    assign cz_in = $signed({{2{s_axis_tdata[47]}}, s_axis_tdata[47:32]})
                   - $signed({az_off_reg[16], az_off_reg});
    assign gz_in = $signed({s_axis_tdata[63], s_axis_tdata[63:48]})
                   - $signed({gz_off_reg[15], gz_off_reg});

    assign cx_mag  = cx_reg[16] ? 17'(-cx_reg) : 17'(cx_reg);
    assign off_mag = ax_off_reg[15] ? 17'(-$signed({ax_off_reg[15], ax_off_reg}))
                                    : {1'b0, ax_off_reg};
    assign sqy_full = cy_reg * cy_reg;
    assign sqz_full = cz_reg * cz_reg;

    always_comb
    begin
        yaw_sum   = yaw_reg + 28'(gprod_reg);
        yaw_wrap1 = (yaw_sum > YAW_HALF) ? yaw_sum - YAW_FULL : yaw_sum;
        yaw_wrap2 = (yaw_wrap1 < -YAW_HALF) ? yaw_wrap1 + YAW_FULL : yaw_wrap1;
        vel_sum   = 49'(vel_reg) + 49'(vprod_reg);
        if (vel_sum > VEL_MAX)
            vel_sat = VEL_MAX;
        else if (vel_sum < VEL_MIN)
            vel_sat = VEL_MIN;
        else
            vel_sat = vel_sum;
        d_full  = vel_reg * $signed({1'b0, ms_reg});
        pos_sum = 65'(pos_reg) + 65'(d_reg);
        yaw_mag = yaw_reg[27] ? 25'(-yaw_reg) : 25'(yaw_reg);
        yaw_out = yaw_neg_reg ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
    end

    // chain entry: roll vector during S_MUL, pitch vector once the root is ready
    always_comb
    begin
        launch       = '0;
        launch.valid = 1'b0;
        if (state_reg == S_MUL)
        begin
            launch.valid = 1'b1;
            launch.pitch = 1'b0;
            launch.zero  = (cy_reg == 17'sd0) && (cz_reg == 18'sd0);
            launch.x     = XY_W'(cz_reg) <<< 14;
            launch.y     = XY_W'(cy_reg) <<< 14;
            launch.z     = '0;
            if (cz_reg < 0)
            begin
                launch.x = -(XY_W'(cz_reg) <<< 14);
                launch.y = -(XY_W'(cy_reg) <<< 14);
                launch.z = (cy_reg >= 0) ? HALF_TURN_Z : -HALF_TURN_Z;
            end
        end
        else if (state_reg == S_ROOT && sqrt_done && div_done)
        begin
            launch.valid = 1'b1;
            launch.pitch = 1'b1;
            launch.zero  = (cx_reg == 17'sd0) && (root == 31'd0);
            launch.x     = $signed({{(XY_W-31){1'b0}}, root});
            launch.y     = -(XY_W'(cx_reg) <<< 14);
            launch.z     = '0;
        end
    end

    assign chain[0] = launch;

    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_cell
        imu_cordic_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .stage (5'(k)),
            .din   (chain[k]),
            .dout  (chain[k+1])
        );
    end

    assign tail = chain[CORDIC_STAGES];

    always_comb
    begin
        lim      = tail.pitch ? Z_W'(PITCH_LIM) : Z_W'(ROLL_LIM);
        ang_full = (tail.z + Z_W'(256)) >>> 9;
        if (tail.zero)
            ang_clamped = '0;
        else if (ang_full > lim)
            ang_clamped = lim;
        else if (ang_full < -lim)
            ang_clamped = -lim;
        else
            ang_clamped = ang_full;
    end

    assign sqrt_start = (state_reg == S_PMUL);
    assign div_start  = (state_reg == S_POS);

    imu_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({sq_sum_reg, 28'd0}),
        .done     (sqrt_done),
        .root     (root)
    );

    imu_yaw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (yaw_n_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign load_out = done_reg && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            ax_off_reg    <= '0;
            ay_off_reg    <= '0;
            az_off_reg    <= '0;
            gz_off_reg    <= '0;
            yaw_reg       <= '0;
            vel_reg       <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_AX_OFF: ax_off_reg <= cfg_data[15:0];
                    REG_AY_OFF: ay_off_reg <= cfg_data[15:0];
                    REG_AZ_OFF: az_off_reg <= cfg_data;
                    REG_GZ_OFF: gz_off_reg <= cfg_data[15:0];
                endcase
            end

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (load_out)
                        done_reg <= 1'b0;
                    if (in_fire && (!done_reg || load_out))
                        state_reg <= S_MUL;
                end
                S_MUL:  state_reg <= S_ACC;
                S_ACC:
                begin
                    yaw_reg <= yaw_wrap2;
                    if (gate_reg)
                        vel_reg <= 48'(vel_sat);
                    state_reg <= S_PMUL;
                end
                S_PMUL: state_reg <= S_POS;
                S_POS:
                begin
                    if (gate_reg)
                    begin
                        if (pos_sum > POS_MAX)
                            pos_reg <= 64'(POS_MAX);
                        else if (pos_sum < POS_MIN)
                            pos_reg <= 64'(POS_MIN);
                        else
                            pos_reg <= 64'(pos_sum);
                    end
                    state_reg <= S_ROOT;
                end
                S_ROOT:
                begin
                    if (sqrt_done && div_done)
                        state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (tail.valid && tail.pitch)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cx_reg <= cx_in;
            cy_reg <= cy_in;
            cz_reg <= cz_in;
            gz_reg <= gz_in;
            ms_reg <= s_axis_tdata[71:64];
        end
        if (state_reg == S_MUL)
        begin
            sqy_reg   <= 32'(sqy_full);
            sqz_reg   <= 33'(sqz_full);
            gprod_reg <= gz_reg * $signed({1'b0, ms_reg});
            vprod_reg <= cx_reg * $signed({1'b0, ms_reg});
            gate_reg  <= cx_mag > off_mag;
        end
        if (state_reg == S_ACC)
            sq_sum_reg <= {2'b0, sqy_reg} + {1'b0, sqz_reg};
        if (state_reg == S_PMUL)
        begin
            d_reg       <= 56'(d_full);
            yaw_n_reg   <= {yaw_mag, 7'd0} + YAW_RND;
            yaw_neg_reg <= yaw_reg[27];
        end
        if (tail.valid && !tail.pitch)
            roll_reg <= 16'(ang_clamped);
        if (tail.valid && tail.pitch)
            pitch_reg <= 15'(ang_clamped);
        if (load_out)
            out_data_reg <= {1'b0, pos_reg, vel_reg, yaw_out, pitch_reg, roll_reg};
    end

    // the state machine leaves idle only after a sample beat is taken
    // (a result still waiting for the output register holds in idle)
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (!done_reg || load_out) |=> state_reg == S_MUL)
        else $error("accepted sample did not start work");

    a_pitch_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid && tail.pitch |-> state_reg == S_WAIT)
        else $error("pitch beat left chain outside wait state");

    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        yaw_reg <= YAW_HALF && yaw_reg >= -YAW_HALF)
        else $error("yaw accumulator out of wrapped range");

    a_roll_before_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROOT |-> !(tail.valid && tail.pitch))
        else $error("pitch beat while root pending");

endmodule

### hdl/imu_cordic_cell.sv
// ----------------------------------------------------------------------------
// CORDIC cell
// One vectoring micro-rotation; registers the beat for the next cell.
// ----------------------------------------------------------------------------
module imu_cordic_cell
    import imu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [4:0]   stage,
    input  cordic_beat_t din,
    output cordic_beat_t dout
);

    cordic_beat_t           beat_reg;
    cordic_beat_t           beat_next;
    logic                   valid_reg;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    always_comb
    begin
        dx        = din.x >>> stage;
        dy        = din.y >>> stage;
        beat_next = din;
        if (din.y > 0)
        begin
            beat_next.x = din.x + dy;
            beat_next.y = din.y - dx;
            beat_next.z = din.z + atan_lut(stage);
        end
        else
        begin
            beat_next.x = din.x - dy;
            beat_next.y = din.y + dx;
            beat_next.z = din.z - atan_lut(stage);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= din.valid;
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    always_comb
    begin
        dout       = beat_reg;
        dout.valid = valid_reg;
    end

endmodule

### hdl/imu_isqrt.sv
// ----------------------------------------------------------------------------
// Integer square root
// Digit-by-digit root of a 62-bit radicand, one result bit per cycle.
// ----------------------------------------------------------------------------
module imu_isqrt
    import imu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [61:0] radicand,
    output logic        done,
    output logic [30:0] root
);

    logic        busy_reg;
    logic        done_reg;
    logic [61:0] n_reg;
    logic [61:0] r_reg;
    logic [61:0] bit_reg;
    logic [62:0] trial;

    assign trial = {1'b0, r_reg} + {1'b0, bit_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg && bit_reg[0])
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= radicand;
            r_reg   <= '0;
            bit_reg <= 62'd1 << 60;
        end
        else if (busy_reg)
        begin
            if ({1'b0, n_reg} >= trial)
            begin
                n_reg <= n_reg - trial[61:0];
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[30:0];

endmodule

### hdl/imu_yaw_div.sv
// ----------------------------------------------------------------------------
// Yaw divider
// Division by 131000 through a reciprocal multiply; the quotient is
// registered on start.
// ----------------------------------------------------------------------------
module imu_yaw_div
    import imu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    output logic        done,
    output logic [14:0] quotient
);

    logic        done_reg;
    logic [14:0] q_reg;
    logic [58:0] prod;

    assign prod = 59'(dividend[31:3]) * 59'(YAW_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else if (start)
            done_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (start)
            q_reg <= 15'(prod >> YAW_RECIP_SHIFT);
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

### tb/imu_tilt_yaw_and_dead_reckoning_unit_test.sv
// ----------------------------------------------------------------------------
// IMU tilt/yaw/dead-reckoning unit testbench
// Streams sensor samples through the unit under several bias settings, with
// random idle bursts on both sides. Roll, pitch, yaw, velocity and position
// of every sample are predicted here and checked against each output beat.
// ----------------------------------------------------------------------------
module imu_tilt_yaw_and_dead_reckoning_unit_test
    import imu_pkg::*;
();

    localparam int  STALL_LIMIT = 5000;
    localparam longint POS_TOP  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint POS_BOT  = -POS_TOP - 1;
    localparam longint VEL_TOP  = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint VEL_BOT  = -VEL_TOP - 1;
    localparam longint YAW_HALF_TURN = 23580000;
    localparam longint YAW_FULL_TURN = 47160000;
    localparam longint ARCTAN_DEG[24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic signed [47:0] vel;
        logic signed [63:0] pos;
    } motion_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [159:0] m_axis_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [16:0]  cfg_data;

    logic [71:0] sample_q[$];
    motion_t     motion_q[$];
    longint      ax_bias, ay_bias, az_bias, gz_bias;
    longint      yaw_acc, vel_acc, pos_acc;
    int          errors;
    int          gap_left;
    int          stall_left;
    int          idle_cycles;
    bit          quiet;

    imu_tilt_yaw_and_dead_reckoning_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint vector_angle(longint y, longint x, longint lim);
        longint z;
        longint dx;
        longint dy;
        longint a;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0)
        begin
            z = (y >= 0) ? 180 * 65536 : -180 * 65536;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++)
        begin
            dx = x >>> i;
            dy = y >>> i;
            if (y > 0)
            begin
                x = x + dy;
                y = y - dx;
                z = z + ARCTAN_DEG[i];
            end
            else
            begin
                x = x - dy;
                y = y + dx;
                z = z - ARCTAN_DEG[i];
            end
        end
        a = (z + 256) >>> 9;
        if (a > lim) a = lim;
        if (a < -lim) a = -lim;
        return a;
    endfunction

    function automatic motion_t predict_motion(logic [71:0] d);
        motion_t r;
        longint cx, cy, cz, gz, ms, yo, v, dp, bmag, amag;
        longint unsigned sq;
        cx = longint'($signed(d[15:0])) - ax_bias;
        cy = longint'($signed(d[31:16])) - ay_bias;
        cz = longint'($signed(d[47:32])) - az_bias;
        gz = longint'($signed(d[63:48])) - gz_bias;
        ms = longint'(d[71:64]);
        r.roll = 16'(vector_angle(cy * 16384, cz * 16384, 23040));
        sq = longint'(cy * cy + cz * cz) << 28;
        r.pitch = 15'(vector_angle(-cx * 16384, longint'(int_sqrt(sq)), 11520));
        yaw_acc = yaw_acc + gz * ms;
        if (yaw_acc > YAW_HALF_TURN) yaw_acc = yaw_acc - YAW_FULL_TURN;
        if (yaw_acc < -YAW_HALF_TURN) yaw_acc = yaw_acc + YAW_FULL_TURN;
        if (yaw_acc >= 0)
            yo = (yaw_acc * 128 + 65500) / 131000;
        else
            yo = -((-yaw_acc * 128 + 65500) / 131000);
        r.yaw = 16'(yo);
        amag = cx < 0 ? -cx : cx;
        bmag = ax_bias < 0 ? -ax_bias : ax_bias;
        if (amag > bmag)
        begin
            v = vel_acc + cx * ms;
            if (v > VEL_TOP) v = VEL_TOP;
            if (v < VEL_BOT) v = VEL_BOT;
            vel_acc = v;
            dp = v * ms;
            if (dp > 0 && pos_acc > POS_TOP - dp)
                pos_acc = POS_TOP;
            else if (dp < 0 && pos_acc < POS_BOT - dp)
                pos_acc = POS_BOT;
            else
                pos_acc = pos_acc + dp;
        end
        r.vel = 48'(vel_acc);
        r.pos = pos_acc;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // drive sample beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            gap_left      = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                motion_q.push_back(predict_motion(s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (sample_q.size() > 0)
                begin
                    s_axis_tdata  <= sample_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if (!quiet && $urandom_range(0, 7) == 0)
                        gap_left = $urandom_range(1, 19);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // drive output backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    = 0;
        end
        else if (quiet)
            m_axis_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 19);
            m_axis_tready <= (stall_left == 0);
        end
    end

    // check result beats
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (motion_q.size() == 0)
                report_mismatch("result beat with nothing outstanding");
            else
            begin
                motion_t e;
                e = motion_q.pop_front();
                if (m_axis_tdata[15:0] !== e.roll)
                    report_mismatch($sformatf("roll %0d, want %0d",
                        $signed(m_axis_tdata[15:0]), e.roll));
                if (m_axis_tdata[30:16] !== e.pitch)
                    report_mismatch($sformatf("pitch %0d, want %0d",
                        $signed(m_axis_tdata[30:16]), e.pitch));
                if (m_axis_tdata[46:31] !== e.yaw)
                    report_mismatch($sformatf("yaw %0d, want %0d",
                        $signed(m_axis_tdata[46:31]), e.yaw));
                if (m_axis_tdata[94:47] !== e.vel)
                    report_mismatch($sformatf("velocity %0d, want %0d",
                        $signed(m_axis_tdata[94:47]), e.vel));
                if (m_axis_tdata[158:95] !== e.pos)
                    report_mismatch($sformatf("position %0d, want %0d",
                        $signed(m_axis_tdata[158:95]), e.pos));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic logic [71:0] sample_beat(int ax, int ay, int az, int gz, int ms);
        return {8'(ms), 16'(gz), 16'(az), 16'(ay), 16'(ax)};
    endfunction

    function automatic logic [71:0] random_sample();
        if ($urandom_range(0, 9) < 7)
            return 72'({$urandom(), $urandom(), $urandom()});
        return sample_beat($urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
            16384 + $urandom_range(0, 4000) - 2000, $urandom_range(0, 600) - 300,
            $urandom_range(0, 40));
    endfunction

    task automatic write_bias(logic [1:0] idx, int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 17'(value);
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_AX_OFF: ax_bias = value;
            REG_AY_OFF: ay_bias = value;
            REG_AZ_OFF: az_bias = value;
            default:    gz_bias = value;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(int ax, int ay, int az, int gz, int count);
        while (sample_q.size() > 0 || s_axis_tvalid || motion_q.size() > 0)
            @(negedge clk);
        write_bias(REG_AX_OFF, ax);
        write_bias(REG_AY_OFF, ay);
        write_bias(REG_AZ_OFF, az);
        write_bias(REG_GZ_OFF, gz);
        repeat (count) sample_q.push_back(random_sample());
        while (sample_q.size() > 0 || s_axis_tvalid || motion_q.size() > 0)
            @(negedge clk);
        repeat (80) @(posedge clk);
    endtask

    initial
    begin
        errors        = 0;
        idle_cycles   = 0;
        quiet         = 1'b0;
        ax_bias = 0; ay_bias = 0; az_bias = 0; gz_bias = 0;
        yaw_acc = 0; vel_acc = 0; pos_acc = 0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        rst_n         = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        sample_q.push_back(sample_beat(0, 0, 0, 0, 0));
        sample_q.push_back(sample_beat(0, 0, 0, 0, 255));
        sample_q.push_back(sample_beat(-32768, -32768, -32768, -32768, 255));
        sample_q.push_back(sample_beat(32767, 32767, 32767, 32767, 255));
        sample_q.push_back(sample_beat(0, 0, 16384, 0, 10));
        sample_q.push_back(sample_beat(16384, 0, 0, 0, 10));
        sample_q.push_back(sample_beat(-16384, 0, 0, 0, 10));
        sample_q.push_back(sample_beat(0, 100, -16384, 0, 1));
        sample_q.push_back(sample_beat(0, -100, -16384, 0, 1));
        sample_q.push_back(sample_beat(0, 0, -16384, 0, 1));
        sample_q.push_back(sample_beat(0, 16384, 0, 0, 1));
        sample_q.push_back(sample_beat(0, -16384, 0, 0, 1));
        sample_q.push_back(sample_beat(5, 0, 0, 0, 1));
        repeat (4) sample_q.push_back(sample_beat(100, 0, 16384, 32767, 255));
        repeat (4) sample_q.push_back(sample_beat(-100, 0, 16384, -32768, 255));
        sample_q.push_back(sample_beat(32767, 0, 0, 0, 0));
        run_phase(0, 0, 0, 0, 80);
        run_phase(-32768, 32767, -49152, 32767, 100);
        run_phase(32767, -32768, 16383, -32768, 100);
        run_phase($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
            $urandom_range(0, 65535) - 49152, $urandom_range(0, 65535) - 32768, 100);
        run_phase($urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
            $urandom_range(0, 400) - 200, $urandom_range(0, 100) - 50, 100);
        quiet = 1'b1;
        run_phase($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
            $urandom_range(0, 65535) - 49152, $urandom_range(0, 65535) - 32768, 100);

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
hdl/imu_pkg.sv
hdl/imu_cordic_cell.sv
hdl/imu_isqrt.sv
hdl/imu_yaw_div.sv
hdl/imu_tilt_yaw_and_dead_reckoning_unit.sv
tb/imu_tilt_yaw_and_dead_reckoning_unit_test.sv
